// ----- rtl/core/srcg_pkg.sv -----
// ----------------------------------------------------------------------------
// Scrolling rainbow column generator package
// Shared types, constants and the fixed color palette.
// ----------------------------------------------------------------------------
`default_nettype none

package srcg_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COLOR_WIDTH  = 2'd0;
    localparam logic [1:0] REG_STEP_TIME_MS = 2'd1;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] COLOR_WIDTH_RESET  = 16'd8;
    localparam logic [15:0] STEP_TIME_RESET    = 16'd50;
    localparam logic [6:0]  COLUMN_COUNT_RESET = 7'd16;

    // Color channel selectors.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS_DIV,
        ST_BLEND_MUL,
        ST_BLEND_DIV,
        ST_EMIT,
        ST_UPDATE
    } state_t;

    // Result of one restoring division step: quotient bit and new remainder.
    typedef struct packed {
        logic        qbit;
        logic [15:0] rem;
    } div_step_t;

    // One restoring division step: shift in a numerator bit, compare, subtract.
    function automatic div_step_t div_step(input logic [15:0] rem_in,
                                           input logic        num_bit,
                                           input logic [15:0] divisor);
        logic [16:0] trial;
        div_step_t   res;
        trial = {rem_in, num_bit};
        if (trial >= {1'b0, divisor}) begin
            res.qbit = 1'b1;
            res.rem  = 16'(trial - {1'b0, divisor});
        end else begin
            res.qbit = 1'b0;
            res.rem  = trial[15:0];
        end
        return res;
    endfunction

    // Palette channel lookup. Slots past the seventh entry are black.
    function automatic logic [7:0] palette_chan(input logic [3:0] idx,
                                                input logic [1:0] ch);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:    rgb = {8'd255, 8'd0,   8'd0};
            4'd1:    rgb = {8'd255, 8'd165, 8'd0};
            4'd2:    rgb = {8'd255, 8'd255, 8'd0};
            4'd3:    rgb = {8'd0,   8'd255, 8'd0};
            4'd4:    rgb = {8'd0,   8'd0,   8'd255};
            4'd5:    rgb = {8'd75,  8'd0,   8'd255};
            4'd6:    rgb = {8'd143, 8'd0,   8'd200};
            default: rgb = 24'd0;
        endcase
        unique case (ch)
            CH_RED:   return rgb[23:16];
            CH_GREEN: return rgb[15:8];
            CH_BLUE:  return rgb[7:0];
            default:  return 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scrolling_rainbow_column_generator_top.sv -----
// ----------------------------------------------------------------------------
// Scrolling rainbow column generator
// Emits one blended palette color per display column for each animation
// tick and advances the scroll position from accumulated elapsed time.
// ----------------------------------------------------------------------------
// Each accepted tick produces column_count results (capped at MAX_COLUMNS),
// one per column in order, with last_column set on the final one. A single
// restoring divider that retires two quotient bits per cycle does all the
// work: it first splits the scroll position into palette index and
// remainder, then for every column runs the three channels in turn, each a
// multiply step and then divide steps, and hands the result to the output
// register. The input is not ready while a tick is in progress; the output
// register lets the next column compute while the previous result waits to
// be taken. Configuration must be written only while idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_rainbow_column_generator_top #(
    parameter int MAX_COLUMNS  = 64,
    parameter int PALETTE_SIZE = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Tick input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_elapsed_ms,
    // Column color output channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_column,
    output logic [15:0]      m_red_level,
    output logic [15:0]      m_green_level,
    output logic [15:0]      m_blue_level,
    output logic             m_last_column
);

    localparam int CW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [CW-1:0] PAL_LAST = CW'(PALETTE_SIZE - 1);
    localparam logic [CW:0]   PAL_SIZE = (CW + 1)'(PALETTE_SIZE);
    localparam logic [6:0]    MAX_COLS = 7'(MAX_COLUMNS);

    // Configuration registers
    logic [15:0] color_width_reg;
    logic [15:0] step_time_reg;
    logic [6:0]  column_count_reg;

    // Persistent state
    logic [31:0] scroll_step_reg, scroll_step_next;
    logic [31:0] time_acc_reg,    time_acc_next;

    // Sequencer and datapath registers
    srcg_pkg::state_t state_reg, state_next;
    logic [15:0]   elapsed_reg,   elapsed_next;
    logic [31:0]   pos_reg,       pos_next;
    logic [15:0]   rem_reg,       rem_next;
    logic [CW-1:0] cur_reg,       cur_next;
    logic [CW-1:0] qmod_reg,      qmod_next;
    logic [15:0]   div_rem_reg,   div_rem_next;
    logic [31:0]   div_num_reg,   div_num_next;
    logic [3:0]    cnt_reg,       cnt_next;
    logic [1:0]    ch_reg,        ch_next;
    logic [6:0]    col_reg,       col_next;
    logic [15:0]   lvl_r_reg,     lvl_r_next;
    logic [15:0]   lvl_g_reg,     lvl_g_next;
    logic [15:0]   lvl_b_reg,     lvl_b_next;

    // Output register
    logic          m_valid_reg,   m_valid_next;
    logic [5:0]    m_column_reg,  m_column_next;
    logic [15:0]   m_red_reg,     m_red_next;
    logic [15:0]   m_green_reg,   m_green_next;
    logic [15:0]   m_blue_reg,    m_blue_next;
    logic          m_last_reg,    m_last_next;

    // Effective configuration with the out-of-range cases folded in.
    logic [15:0] w_eff;
    logic [6:0]  n_eff;

    assign w_eff = (color_width_reg == 16'd0) ? 16'd1 : color_width_reg;
    assign n_eff = (column_count_reg > MAX_COLS) ? MAX_COLS : column_count_reg;

    // Reduce (2 * q + bit) modulo the palette size with one subtract.
    function automatic logic [CW-1:0] mod_step(input logic [CW-1:0] q,
                                               input logic          b);
        logic [CW:0] t;
        t = {q, b};
        if (t >= PAL_SIZE) begin
            t = t - PAL_SIZE;
        end
        return t[CW-1:0];
    endfunction

    // Shared divider: two restoring steps per cycle.
    srcg_pkg::div_step_t d1, d2;
    logic [31:0]   div_num_shift;
    logic [CW-1:0] qm1, qm2;

    always_comb begin
        d1            = srcg_pkg::div_step(div_rem_reg, div_num_reg[31], w_eff);
        d2            = srcg_pkg::div_step(d1.rem, div_num_reg[30], w_eff);
        div_num_shift = {div_num_reg[29:0], d1.qbit, d2.qbit};
        qm1           = mod_step(qmod_reg, d1.qbit);
        qm2           = mod_step(qm1, d2.qbit);
    end

    // Blend numerator (before the 8-bit shift): (w - r) * c0 + r * c1.
    logic [CW-1:0] nxt_idx;
    logic [7:0]    c0, c1;
    logic [23:0]   prod_a, prod_b;
    logic [23:0]   blend_sum;

    always_comb begin
        nxt_idx   = (cur_reg == PAL_LAST) ? '0 : cur_reg + 1'b1;
        c0        = srcg_pkg::palette_chan(4'(cur_reg), ch_reg);
        c1        = srcg_pkg::palette_chan(4'(nxt_idx), ch_reg);
        prod_a    = 16'(w_eff - rem_reg) * c0;
        prod_b    = rem_reg * c1;
        blend_sum = prod_a + prod_b;
    end

    // Saturating time accumulation.
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;

    always_comb begin
        acc_sum = {1'b0, time_acc_reg} + {17'd0, elapsed_reg};
        acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    end

    // Handshake decode.
    logic in_fire;
    logic out_free;
    logic last_col;
    logic [16:0] rem_inc;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_col = ((col_reg + 7'd1) == n_eff);
    assign rem_inc  = {1'b0, rem_reg} + 17'd1;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srcg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (n_eff == 7'd0) ? srcg_pkg::ST_UPDATE
                                                 : srcg_pkg::ST_POS_DIV;
                end
            end
            srcg_pkg::ST_POS_DIV: begin
                if (cnt_reg == 4'd15) begin
                    state_next = srcg_pkg::ST_BLEND_MUL;
                end
            end
            srcg_pkg::ST_BLEND_MUL: begin
                state_next = srcg_pkg::ST_BLEND_DIV;
            end
            srcg_pkg::ST_BLEND_DIV: begin
                if (cnt_reg == 4'd7) begin
                    state_next = (ch_reg == srcg_pkg::CH_BLUE) ? srcg_pkg::ST_EMIT
                                                               : srcg_pkg::ST_BLEND_MUL;
                end
            end
            srcg_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = last_col ? srcg_pkg::ST_UPDATE : srcg_pkg::ST_BLEND_MUL;
                end
            end
            srcg_pkg::ST_UPDATE: begin
                state_next = srcg_pkg::ST_IDLE;
            end
            default: begin
                state_next = srcg_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        s_ready          = (state_reg == srcg_pkg::ST_IDLE);
        scroll_step_next = scroll_step_reg;
        time_acc_next    = time_acc_reg;
        elapsed_next     = elapsed_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        cur_next         = cur_reg;
        qmod_next        = qmod_reg;
        div_rem_next     = div_rem_reg;
        div_num_next     = div_num_reg;
        cnt_next         = cnt_reg;
        ch_next          = ch_reg;
        col_next         = col_reg;
        lvl_r_next       = lvl_r_reg;
        lvl_g_next       = lvl_g_reg;
        lvl_b_next       = lvl_b_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        m_column_next    = m_column_reg;
        m_red_next       = m_red_reg;
        m_green_next     = m_green_reg;
        m_blue_next      = m_blue_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            srcg_pkg::ST_IDLE: begin
                // Start splitting the scroll position into quotient and remainder.
                if (in_fire) begin
                    elapsed_next = s_elapsed_ms;
                    pos_next     = scroll_step_reg;
                    div_num_next = scroll_step_reg;
                    div_rem_next = 16'd0;
                    qmod_next    = '0;
                    cnt_next     = 4'd0;
                    col_next     = 7'd0;
                end
            end
            srcg_pkg::ST_POS_DIV: begin
                // Quotient is reduced modulo the palette size as it forms.
                div_num_next = div_num_shift;
                div_rem_next = d2.rem;
                qmod_next    = qm2;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    rem_next = d2.rem;
                    cur_next = qm2;
                    ch_next  = srcg_pkg::CH_RED;
                end
            end
            srcg_pkg::ST_BLEND_MUL: begin
                // Numerator is blend_sum * 256; its top half is already below w.
                div_rem_next = blend_sum[23:8];
                div_num_next = {blend_sum[7:0], 24'd0};
                cnt_next     = 4'd0;
            end
            srcg_pkg::ST_BLEND_DIV: begin
                div_num_next = div_num_shift;
                div_rem_next = d2.rem;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    unique case (ch_reg)
                        srcg_pkg::CH_RED:   lvl_r_next = div_num_shift[15:0];
                        srcg_pkg::CH_GREEN: lvl_g_next = div_num_shift[15:0];
                        srcg_pkg::CH_BLUE:  lvl_b_next = div_num_shift[15:0];
                        default:            lvl_b_next = lvl_b_reg;
                    endcase
                    ch_next = ch_reg + 2'd1;
                end
            end
            srcg_pkg::ST_EMIT: begin
                // Hand the column to the output register and step the position.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_column_next = col_reg[5:0];
                    m_red_next    = lvl_r_reg;
                    m_green_next  = lvl_g_reg;
                    m_blue_next   = lvl_b_reg;
                    m_last_next   = last_col;
                    col_next      = col_reg + 7'd1;
                    ch_next       = srcg_pkg::CH_RED;
                    if (pos_reg == 32'hFFFF_FFFF) begin
                        // Position wraps to zero: palette index and remainder restart.
                        pos_next = 32'd0;
                        rem_next = 16'd0;
                        cur_next = '0;
                    end else begin
                        pos_next = pos_reg + 32'd1;
                        if (rem_inc == {1'b0, w_eff}) begin
                            rem_next = 16'd0;
                            cur_next = nxt_idx;
                        end else begin
                            rem_next = rem_inc[15:0];
                        end
                    end
                end
            end
            srcg_pkg::ST_UPDATE: begin
                // Accumulate time and scroll once the step time is exceeded.
                if (acc_sat > {16'd0, step_time_reg}) begin
                    time_acc_next    = 32'd0;
                    scroll_step_next = scroll_step_reg + 32'd1;
                end else begin
                    time_acc_next = acc_sat;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= srcg_pkg::ST_IDLE;
            scroll_step_reg  <= 32'd0;
            time_acc_reg     <= 32'd0;
            m_valid_reg      <= 1'b0;
            color_width_reg  <= srcg_pkg::COLOR_WIDTH_RESET;
            step_time_reg    <= srcg_pkg::STEP_TIME_RESET;
            column_count_reg <= srcg_pkg::COLUMN_COUNT_RESET;
        end else begin
            state_reg       <= state_next;
            scroll_step_reg <= scroll_step_next;
            time_acc_reg    <= time_acc_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    srcg_pkg::REG_COLOR_WIDTH:  color_width_reg  <= cfg_wdata;
                    srcg_pkg::REG_STEP_TIME_MS: step_time_reg    <= cfg_wdata;
                    srcg_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        elapsed_reg  <= elapsed_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        cur_reg      <= cur_next;
        qmod_reg     <= qmod_next;
        div_rem_reg  <= div_rem_next;
        div_num_reg  <= div_num_next;
        cnt_reg      <= cnt_next;
        ch_reg       <= ch_next;
        col_reg      <= col_next;
        lvl_r_reg    <= lvl_r_next;
        lvl_g_reg    <= lvl_g_next;
        lvl_b_reg    <= lvl_b_next;
        m_column_reg <= m_column_next;
        m_red_reg    <= m_red_next;
        m_green_reg  <= m_green_next;
        m_blue_reg   <= m_blue_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_column      = m_column_reg;
    assign m_red_level   = m_red_reg;
    assign m_green_level = m_green_reg;
    assign m_blue_level  = m_blue_reg;
    assign m_last_column = m_last_reg;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling rainbow column generator testbench
// Sends animation ticks to the generator and checks every column color it
// returns against an in-bench model of the scroll position, palette blend and
// elapsed-time accumulator. Directed tests cover the register extremes and
// corner cases, then randomized phases run with random settings, random gaps
// on the tick side and random stalls on the color side.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int MAX_COLUMNS   = 64;
    localparam int PALETTE_SIZE  = 7;
    // Covers the longest tick, at the maximum column count, with margin.
    localparam int SETTLE_CYCLES = 2000;
    localparam int LIMIT_CYCLES  = 10000000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 23;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One expected column color.
    typedef struct {
        logic [5:0]  column;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
    } column_color_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_elapsed_ms;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_column;
    logic [15:0] m_red_level;
    logic [15:0] m_green_level;
    logic [15:0] m_blue_level;
    logic        m_last_column;

    // Shadow copy of the registers and the scroll state.
    logic [15:0] cfg_color_width  = srcg_pkg::COLOR_WIDTH_RESET;
    logic [15:0] cfg_step_time    = srcg_pkg::STEP_TIME_RESET;
    logic [6:0]  cfg_column_count = srcg_pkg::COLUMN_COUNT_RESET;
    logic [31:0] scroll_pos       = '0;
    logic [31:0] elapsed_total    = '0;

    column_color_t expected_colors[$];
    column_color_t oldest_color;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   hold_request   = 0;
    bit            no_idle        = 1'b0;

    scrolling_rainbow_column_generator_top #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .PALETTE_SIZE(PALETTE_SIZE)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elapsed_ms (s_elapsed_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column     (m_column),
        .m_red_level  (m_red_level),
        .m_green_level(m_green_level),
        .m_blue_level (m_blue_level),
        .m_last_column(m_last_column)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the design hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fixed rainbow palette; slots past the seventh are black.
    function automatic logic [23:0] rainbow_rgb(input int unsigned slot);
        case (slot)
            0:       return 24'hFF0000;
            1:       return 24'hFFA500;
            2:       return 24'hFFFF00;
            3:       return 24'h00FF00;
            4:       return 24'h0000FF;
            5:       return 24'h4B00FF;
            6:       return 24'h8F00C8;
            default: return 24'h000000;
        endcase
    endfunction

    // Linear blend of two 8-bit levels into 8.8 fixed point, truncated.
    function automatic logic [15:0] mix_channel(input logic [7:0]  start_lvl,
                                                input logic [7:0]  end_lvl,
                                                input logic [31:0] rem,
                                                input logic [31:0] w);
        logic [63:0] num;
        num = ((64'(w) - 64'(rem)) * 64'(start_lvl) + 64'(rem) * 64'(end_lvl)) << 8;
        return 16'(num / 64'(w));
    endfunction

    // Work out the colors one tick produces, then advance the scroll state.
    task automatic predict_tick_colors(input logic [15:0] ms);
        logic [31:0]   w;
        logic [31:0]   p;
        logic [31:0]   rem;
        logic [23:0]   c0;
        logic [23:0]   c1;
        int unsigned   n;
        int unsigned   cur;
        int unsigned   nxt;
        column_color_t item;
        w = (cfg_color_width == 16'd0) ? 32'd1 : 32'(cfg_color_width);
        n = (cfg_column_count > MAX_COLUMNS) ? MAX_COLUMNS : cfg_column_count;
        for (int unsigned x = 0; x < n; x++) begin
            p   = scroll_pos + x;
            cur = (p / w) % PALETTE_SIZE;
            nxt = (cur + 1) % PALETTE_SIZE;
            rem = p % w;
            c0  = rainbow_rgb(cur);
            c1  = rainbow_rgb(nxt);
            item.column = 6'(x);
            item.red    = mix_channel(c0[23:16], c1[23:16], rem, w);
            item.green  = mix_channel(c0[15:8], c1[15:8], rem, w);
            item.blue   = mix_channel(c0[7:0], c1[7:0], rem, w);
            item.last   = (x + 1 == n);
            expected_colors.push_back(item);
        end
        // The accumulator saturates, then clears once it passes the step time.
        if (elapsed_total > 32'hFFFF_FFFF - 32'(ms)) elapsed_total = '1;
        else elapsed_total = elapsed_total + 32'(ms);
        if (elapsed_total > 32'(cfg_step_time)) begin
            elapsed_total = '0;
            scroll_pos    = scroll_pos + 32'd1;
        end
    endtask

    // Offer one tick and wait for the transaction to complete.
    task automatic send_tick(input logic [15:0] ms);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_elapsed_ms <= ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tick_colors(ms);
    endtask

    // Stop offering ticks and let every expected color come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the shadow copy follows the register width.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            srcg_pkg::REG_COLOR_WIDTH:  cfg_color_width  = data;
            srcg_pkg::REG_STEP_TIME_MS: cfg_step_time    = data;
            srcg_pkg::REG_COLUMN_COUNT: cfg_column_count = data[6:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [15:0] width,
                                    input logic [15:0] step_ms,
                                    input logic [15:0] columns);
        wait_idle();
        write_reg(srcg_pkg::REG_COLOR_WIDTH, width);
        write_reg(srcg_pkg::REG_STEP_TIME_MS, step_ms);
        write_reg(srcg_pkg::REG_COLUMN_COUNT, columns);
        cfg_we <= 1'b0;
    endtask

    // Color side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every color transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected color for column %0d", m_column);
                mismatch_count++;
            end else begin
                oldest_color = expected_colors.pop_front();
                check_field("column", oldest_color.column, m_column);
                check_field("red_level", oldest_color.red, m_red_level);
                check_field("green_level", oldest_color.green, m_green_level);
                check_field("blue_level", oldest_color.blue, m_blue_level);
                check_field("last_column", oldest_color.last, m_last_column);
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Reset values, and the step time being passed only when exceeded.
    task automatic test_defaults();
        send_tick(16'd0);
        send_tick(16'd50);
        send_tick(16'd1);
        send_tick(16'hFFFF);
    endtask

    // With a zero step time any nonzero elapsed time scrolls one column.
    task automatic test_step_time_zero();
        program_settings(16'd1, 16'd0, 16'd64);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'd0);
        send_tick(16'hFFFF);
    endtask

    // Widest color span with the longest step time, then a zero width.
    task automatic test_width_extremes();
        program_settings(16'hFFFF, 16'hFFFF, 16'd1);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'd0);
        program_settings(16'd0, 16'd2, 16'd7);
        send_tick(16'd3);
        send_tick(16'd3);
    endtask

    // Column counts past the maximum, zero columns and an unused index.
    task automatic test_column_limits();
        program_settings(16'd3, 16'd3, 16'hFFFF);
        send_tick(16'd4);
        send_tick(16'd4);
        // Zero columns: nothing comes out but time still accumulates.
        program_settings(16'd3, 16'd3, 16'hFF80);
        send_tick(16'd4);
        send_tick(16'd2);
        send_tick(16'd2);
        program_settings(16'd5, 16'd1, 16'd65);
        send_tick(16'd9);
        wait_idle();
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        send_tick(16'd7);
    endtask

    // Hold the color side off so the block fills up and stalls its input.
    task automatic test_backpressure();
        program_settings(16'd2, 16'd0, 16'd64);
        no_idle      = 1'b1;
        hold_request = 1500;
        repeat (4) send_tick(16'($urandom));
        no_idle = 1'b0;
    endtask

    function automatic logic [15:0] pick_color_width();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom);
        return 16'($urandom_range(1, 9));
    endfunction

    function automatic logic [15:0] pick_step_time();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2) return 16'd0;
        if (r == 2) return 16'hFFFF;
        if (r < 7) return 16'($urandom);
        return 16'($urandom_range(1, 40));
    endfunction

    // Mostly small column counts; the upper data bits are random at times.
    function automatic logic [15:0] pick_column_count();
        int unsigned r;
        logic [6:0]  cols;
        r = $urandom_range(0, 19);
        if (r == 0) cols = 7'd0;
        else if (r == 1) cols = 7'd64;
        else if (r == 2) cols = 7'($urandom_range(65, 127));
        else if (r == 3) cols = 7'($urandom_range(17, 63));
        else cols = 7'($urandom_range(1, 16));
        if ($urandom_range(0, 1) == 0) return {9'd0, cols};
        return {9'($urandom), cols};
    endfunction

    // Elapsed times mostly around the step time so the scroll keeps moving.
    function automatic logic [15:0] pick_elapsed();
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom);
        top = cfg_step_time + cfg_step_time / 2 + 2;
        if (top > 16'hFFFF) top = 16'hFFFF;
        return 16'($urandom_range(0, top));
    endfunction

    task automatic test_random();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_settings(pick_color_width(), pick_step_time(), pick_column_count());
            no_idle = (phase % 4 == 1);
            repeat (PHASE_TICKS) send_tick(pick_elapsed());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= srcg_pkg::REG_COLOR_WIDTH;
        cfg_wdata    <= 16'd0;
        s_valid      <= 1'b0;
        s_elapsed_ms <= 16'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_step_time_zero();
        test_width_extremes();
        test_column_limits();
        test_backpressure();
        test_random();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- scrolling_rainbow_column_generator_top.f -----
rtl/core/srcg_pkg.sv
rtl/core/scrolling_rainbow_column_generator_top.sv
sim/tb_top.sv
